// File: sv/bci_pkg.sv
// Shared constants, codes and word types of the breakpoint curve interpolator.
`default_nettype none
package bci_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DATA_W     = 32;
   localparam int HELD_W     = 5;
   localparam int STEP_W     = $clog2(DATA_W);
   localparam int ALU_W      = DATA_W + 2;
   localparam int CSR_ADDR_W = 3;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_EVAL   = 2'd2;

   localparam logic [2:0] OUT_FALLBACK = 3'd0;
   localparam logic [2:0] OUT_FIRST    = 3'd1;
   localparam logic [2:0] OUT_LAST     = 3'd2;
   localparam logic [2:0] OUT_INTERP   = 3'd3;
   localparam logic [2:0] OUT_STEP     = 3'd4;
   localparam logic [2:0] OUT_STORED   = 3'd5;
   localparam logic [2:0] OUT_FULL     = 3'd6;
   localparam logic [2:0] OUT_CLEARED  = 3'd7;

   typedef struct packed {
      logic [1:0]               func;
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] point_value;
      logic                     position_not_finite;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [2:0]               outcome;
      logic [HELD_W-1:0]        points_held;
   } rsp_word_type;

   // Sign extension of a data word to the width of the shared adder.
   function automatic logic [ALU_W-1:0] sext_alu(input logic [DATA_W-1:0] x);
      sext_alu = {{(ALU_W - DATA_W){x[DATA_W-1]}}, x};
   endfunction

endpackage
`default_nettype wire

// File: sv/breakpoint_curve_interpolator.sv
// Top level of the breakpoint curve interpolator: table, sequencer and shared adder.
`default_nettype none
//
//   channel  direction  handshake                      word
//   req      in         req_valid / req_stall          bci_pkg::req_word_type
//   rsp      out        rsp_valid / rsp_stall          bci_pkg::rsp_word_type
//   csr      in/out     psel penable pwrite pready     paddr, pwdata, prdata
//
// Clear, append and a fallback evaluation go from acceptance straight to the emit state. Other
// evaluations hold the first or last breakpoint, give a zero-span step, or interpolate with
// the 32-step multiply and 32-step divide on the one shared 34-bit adder. req_stall is high
// from acceptance until the result has moved into the output register. Reset is synchronous and
// empties the table. A result waiting under rsp_stall does not block the next word's acceptance.
module breakpoint_curve_interpolator (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  bci_pkg::req_word_type                   req_word,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output bci_pkg::rsp_word_type                   rsp_word,
   input  wire                                     psel,
   input  wire                                     penable,
   input  wire                                     pwrite,
   input  wire  [bci_pkg::CSR_ADDR_W-1:0]          paddr,
   input  wire  [bci_pkg::DATA_W-1:0]              pwdata,
   output logic [bci_pkg::DATA_W-1:0]              prdata,
   output logic                                    pready
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] S_FIRST = 4'd1;
   localparam logic [ST_W-1:0] S_LAST  = 4'd2;
   localparam logic [ST_W-1:0] S_SCAN  = 4'd3;
   localparam logic [ST_W-1:0] S_SPAN  = 4'd4;
   localparam logic [ST_W-1:0] S_DIFF  = 4'd5;
   localparam logic [ST_W-1:0] S_DV    = 4'd6;
   localparam logic [ST_W-1:0] S_MUL   = 4'd7;
   localparam logic [ST_W-1:0] S_DIV   = 4'd8;
   localparam logic [ST_W-1:0] S_FINAL = 4'd9;
   localparam logic [ST_W-1:0] S_EMIT  = 4'd10;

   localparam int DW = bci_pkg::DATA_W;
   localparam int AW = bci_pkg::ALU_W;

   // The breakpoint table lives in two memories with registered reads.
   logic [DW-1:0] pos_mem [bci_pkg::MAX_POINTS];
   logic [DW-1:0] val_mem [bci_pkg::MAX_POINTS];

   logic [ST_W-1:0]                 state_ff, state_in;
   logic [bci_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [DW-1:0]                   fallback_ff, fallback_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bci_pkg::rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [DW-1:0]                   q_ff, q_in;
   logic [DW-1:0]                   pa_ff, pa_in;
   logic [DW-1:0]                   va_ff, va_in;
   logic [DW-1:0]                   vb_ff, vb_in;
   logic [DW-1:0]                   span_ff, span_in;
   logic [DW-1:0]                   mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic [2*DW-1:0]                 acc_ff, acc_in;
   logic [bci_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [bci_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [DW-1:0]                   res_value_ff, res_value_in;
   logic [2:0]                      res_outcome_ff, res_outcome_in;

   logic [DW-1:0]                   pos_rd_ff;
   logic [DW-1:0]                   val_rd_ff;
   logic [bci_pkg::IDX_W-1:0]       rd_addr;
   logic                            wr_en;

   // Shared adder: sum = a + b or a - b, 34 bits so that signed spans never overflow.
   logic [AW-1:0]                   alu_a;
   logic [AW-1:0]                   alu_b;
   logic                            alu_sub;
   logic [AW-1:0]                   alu_sum;

   logic                            req_take;
   logic                            cfg_write;
   logic [bci_pkg::CNT_W+bci_pkg::HELD_W-1:0] count_ext;

   assign alu_sum   = alu_a + (alu_b ^ {AW{alu_sub}}) + AW'(alu_sub);
   assign req_take  = req_valid && !req_stall;
   assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
   assign count_ext = {{bci_pkg::HELD_W{1'b0}}, count_ff};

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? '0 : fallback_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      fallback_in    = cfg_write ? pwdata : fallback_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_word_in    = rsp_word_ff;
      q_in           = q_ff;
      pa_in          = pa_ff;
      va_in          = va_ff;
      vb_in          = vb_ff;
      span_in        = span_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      idx_in         = idx_ff;
      res_value_in   = res_value_ff;
      res_outcome_in = res_outcome_ff;
      rd_addr        = idx_ff;
      wr_en          = 1'b0;
      alu_a          = '0;
      alu_b          = '0;
      alu_sub        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr      = '0;
            q_in         = req_word.position;
            res_value_in = '0;
            if (req_take) begin
               state_in = S_EMIT;
               unique case (req_word.func)
                  bci_pkg::FUNC_CLEAR: begin
                     count_in       = '0;
                     res_outcome_in = bci_pkg::OUT_CLEARED;
                  end
                  bci_pkg::FUNC_APPEND: begin
                     if (count_ff < bci_pkg::CNT_W'(bci_pkg::MAX_POINTS)) begin
                        wr_en          = 1'b1;
                        count_in       = count_ff + 1'b1;
                        res_outcome_in = bci_pkg::OUT_STORED;
                     end else begin
                        res_outcome_in = bci_pkg::OUT_FULL;
                     end
                  end
                  default: begin
                     // Evaluate; the unused function code is decoded the same way.
                     if (count_ff == '0 || req_word.position_not_finite) begin
                        res_value_in   = fallback_ff;
                        res_outcome_in = bci_pkg::OUT_FALLBACK;
                     end else begin
                        state_in = S_FIRST;
                     end
                  end
               endcase
            end
         end

         S_FIRST: begin
            // Entry zero is on the read port; the last entry is fetched next.
            rd_addr = bci_pkg::IDX_W'(count_ff - 1'b1);
            pa_in   = pos_rd_ff;
            va_in   = val_rd_ff;
            if ($signed(q_ff) <= $signed(pos_rd_ff)) begin
               res_value_in   = val_rd_ff;
               res_outcome_in = bci_pkg::OUT_FIRST;
               state_in       = S_EMIT;
            end else begin
               state_in = S_LAST;
            end
         end

         S_LAST: begin
            rd_addr = bci_pkg::IDX_W'(1);
            idx_in  = bci_pkg::IDX_W'(1);
            if ($signed(q_ff) >= $signed(pos_rd_ff)) begin
               res_value_in   = val_rd_ff;
               res_outcome_in = bci_pkg::OUT_LAST;
               state_in       = S_EMIT;
            end else begin
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // The query lies strictly inside the table's range, so a later
            // point above it is always found before the end.
            if ($signed(q_ff) < $signed(pos_rd_ff)) begin
               span_in  = pos_rd_ff;
               vb_in    = val_rd_ff;
               state_in = S_SPAN;
            end else begin
               pa_in   = pos_rd_ff;
               va_in   = val_rd_ff;
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end

         S_SPAN: begin
            alu_a   = bci_pkg::sext_alu(span_ff);
            alu_b   = bci_pkg::sext_alu(pa_ff);
            alu_sub = 1'b1;
            neg_in  = $signed(vb_ff) < $signed(va_ff);
            if (alu_sum[AW-1] || alu_sum == '0) begin
               res_value_in   = vb_ff;
               res_outcome_in = bci_pkg::OUT_STEP;
               state_in       = S_EMIT;
            end else begin
               span_in  = alu_sum[DW-1:0];
               state_in = S_DIFF;
            end
         end

         S_DIFF: begin
            alu_a    = bci_pkg::sext_alu(q_ff);
            alu_b    = bci_pkg::sext_alu(pa_ff);
            alu_sub  = 1'b1;
            acc_in   = {{DW{1'b0}}, alu_sum[DW-1:0]};
            state_in = S_DV;
         end

         S_DV: begin
            // Magnitude of the value difference, larger minus smaller.
            alu_a    = bci_pkg::sext_alu(neg_ff ? va_ff : vb_ff);
            alu_b    = bci_pkg::sext_alu(neg_ff ? vb_ff : va_ff);
            alu_sub  = 1'b1;
            mag_in   = alu_sum[DW-1:0];
            step_in  = '0;
            state_in = S_MUL;
         end

         S_MUL: begin
            // LSB-first shift-add: high half accumulates, low half holds the multiplier.
            alu_a   = {2'b00, acc_ff[2*DW-1:DW]};
            alu_b   = acc_ff[0] ? {2'b00, mag_ff} : '0;
            acc_in  = {alu_sum[DW:0], acc_ff[DW-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == bci_pkg::STEP_LAST) begin
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            // Restoring divide: the quotient fits 32 bits because the offset is below the span.
            alu_a   = {1'b0, acc_ff[2*DW-1:DW-1]};
            alu_b   = {2'b00, span_ff};
            alu_sub = 1'b1;
            if (alu_sum[AW-1]) begin
               acc_in = {acc_ff[2*DW-2:DW-1], acc_ff[DW-2:0], 1'b0};
            end else begin
               acc_in = {alu_sum[DW-1:0], acc_ff[DW-2:0], 1'b1};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == bci_pkg::STEP_LAST) begin
               state_in = S_FINAL;
            end
         end

         S_FINAL: begin
            alu_a          = bci_pkg::sext_alu(va_ff);
            alu_b          = {2'b00, acc_ff[DW-1:0]};
            alu_sub        = neg_ff;
            res_value_in   = alu_sum[DW-1:0];
            res_outcome_in = bci_pkg::OUT_INTERP;
            state_in       = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.result_value = res_value_ff;
               rsp_word_in.outcome      = res_outcome_ff;
               rsp_word_in.points_held  = count_ext[bci_pkg::HELD_W-1:0];
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         fallback_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fallback_ff  <= fallback_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff    <= rsp_word_in;
      q_ff           <= q_in;
      pa_ff          <= pa_in;
      va_ff          <= va_in;
      vb_ff          <= vb_in;
      span_ff        <= span_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      acc_ff         <= acc_in;
      step_ff        <= step_in;
      idx_ff         <= idx_in;
      res_value_ff   <= res_value_in;
      res_outcome_ff <= res_outcome_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[count_ff[bci_pkg::IDX_W-1:0]] <= req_word.position;
         val_mem[count_ff[bci_pkg::IDX_W-1:0]] <= req_word.point_value;
      end
      pos_rd_ff <= pos_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   // The table never holds more breakpoints than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bci_pkg::CNT_W'(bci_pkg::MAX_POINTS))
      else $error("breakpoint count exceeds table capacity");

   // An accepted append into a table with room grows the count by one.
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_word.func == bci_pkg::FUNC_APPEND &&
       count_ff < bci_pkg::CNT_W'(bci_pkg::MAX_POINTS))
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not store the breakpoint");

   // The partial remainder of the divide stays below the span.
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> acc_ff[2*DW-1:DW] < span_ff)
      else $error("divide remainder reached the span");

endmodule
`default_nettype wire
